[hw/rtl/mbps_pkg.sv]
`default_nettype none
package mbps_pkg;

  localparam int unsigned MaxPatternBytes = 16;
  localparam int unsigned PatBytes        = 16;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned CntW            = 32;
  localparam int unsigned LenW            = 5;
  localparam int unsigned CareW           = 16;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned CfgIdxW         = 3;

  localparam logic [CfgIdxW-1:0] CFG_PAT_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAT_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CARE     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEN      = 3'd3;

  typedef struct packed {
    logic [PatBytes*ByteW-1:0] pattern;
    logic [CareW-1:0]          care;
    logic [LenW-1:0]           len;
  } pat_cfg_t;

endpackage
`default_nettype wire

[hw/rtl/mbps_if.sv]
`default_nettype none
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface
`default_nettype wire

[hw/rtl/mbps_matcher.sv]
`default_nettype none
module mbps_matcher #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MaxPatternBytes
) (
  input  mbps_pkg::pat_cfg_t                      cfg_i,
  input  logic [MAX_PATTERN_BYTES-1:0][7:0]       window_i,
  input  logic [mbps_pkg::CntW-1:0]               count_i,
  output logic                                    match_o
);
  import mbps_pkg::*;

  localparam int unsigned IdxW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  always_comb begin
    logic [LenW-1:0] idx;
    idx     = '0;
    match_o = (cfg_i.len != '0) &&
              (cfg_i.len <= LenW'(MAX_PATTERN_BYTES)) &&
              (count_i >= {{(CntW-LenW){1'b0}}, cfg_i.len});
    // window entry k is the byte k beats ago; pattern byte j aligns to len-1-j
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      if ((LenW'(j) < cfg_i.len) && cfg_i.care[j]) begin
        idx = cfg_i.len - LenW'(j) - LenW'(1);
        if (window_i[idx[IdxW-1:0]] != cfg_i.pattern[ByteW*j +: ByteW]) begin
          match_o = 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/masked_byte_pattern_scanner.sv]
// The result beat is registered and appears in the cycle after the accepted input beat.
// Throughput: one byte per cycle unless a held result stalls the input; the
// window compare and the saturating byte counter update in the same cycle,
// and the result register frees itself whenever the sink takes its beat.
// Reset: asynchronous, active low; clears configuration, counter, report flag
// and output valid.
`default_nettype none
module masked_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MaxPatternBytes
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mbps_pkg::CfgDataW-1:0]     cfg_wdata_i,
  mbps_in_if.sink                           in_i,
  mbps_out_if.source                        out_o
);
  import mbps_pkg::*;

  pat_cfg_t                          cfg_q;
  logic [MAX_PATTERN_BYTES-1:0][7:0] window_q, window_d;
  logic [CntW-1:0]                   seen_q, seen_d;
  logic                              reported_q;
  logic                              out_valid_q;
  logic                              out_found_q;
  logic [CntW-1:0]                   out_offset_q;
  logic                              in_beat;
  logic                              match;
  logic                              emit;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_beat    = in_i.valid && in_i.ready;

  always_comb begin
    window_d = window_q;
    for (int k = MAX_PATTERN_BYTES - 1; k > 0; k--) begin
      window_d[k] = window_q[k-1];
    end
    window_d[0] = in_i.data_byte;
    seen_d      = (seen_q == '1) ? seen_q : seen_q + CntW'(1);
  end

  mbps_matcher #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_matcher (
    .cfg_i   (cfg_q),
    .window_i(window_d),
    .count_i (seen_d),
    .match_o (match)
  );

  assign emit = in_beat && !reported_q && (match || in_i.last_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      seen_q      <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PAT_LOW:  cfg_q.pattern[CfgDataW-1:0]          <= cfg_wdata_i;
          CFG_PAT_HIGH: cfg_q.pattern[2*CfgDataW-1:CfgDataW] <= cfg_wdata_i;
          CFG_CARE:     cfg_q.care                           <= cfg_wdata_i[CareW-1:0];
          CFG_LEN:      cfg_q.len                            <= cfg_wdata_i[LenW-1:0];
          default: ;
        endcase
      end
      if (in_beat) begin
        if (in_i.last_byte) begin
          seen_q     <= '0;
          reported_q <= 1'b0;
        end else begin
          seen_q <= seen_d;
          if (match) begin
            reported_q <= 1'b1;
          end
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      window_q <= window_d;
    end
    if (emit) begin
      out_found_q  <= match;
      out_offset_q <= match ? seen_d - {{(CntW-LenW){1'b0}}, cfg_q.len} : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.match_offset = out_offset_q;

endmodule
`default_nettype wire

[hw/rtl/mbps_checker.sv]
`default_nettype none
module mbps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_found_i,
  input logic [31:0] out_offset_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_found_i) &&
                                    $stable(out_offset_i))
    else $error("result beat changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_offset_i == 32'd0)
    else $error("not-found result with nonzero offset");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result beat without an input beat");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_found_i (out_o.found),
  .out_offset_i(out_o.match_offset)
);
`default_nettype wire

[bench/mbps_checker.sv]
module mbps_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbps_pkg::CfgDataW-1:0] cfg_wdata_i,
  mbps_in_if                            in_i,
  mbps_out_if                           out_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   pending_o,
  output int unsigned                   results_o,
  output int unsigned                   hits_o
);
  import mbps_pkg::*;

  typedef struct packed {
    logic            found;
    logic [CntW-1:0] match_offset;
  } scan_result_t;

  pat_cfg_t         scan_cfg;
  logic [ByteW-1:0] window_q [MaxPatternBytes];
  logic [CntW-1:0]  seen_cnt;
  logic             reported;
  scan_result_t     verdict_q [$];
  scan_result_t     want;

  function automatic logic window_hit();
    if (scan_cfg.len == 0 || scan_cfg.len > MaxPatternBytes) return 1'b0;
    if (seen_cnt < CntW'(scan_cfg.len)) return 1'b0;
    for (int j = 0; j < int'(scan_cfg.len); j++) begin
      if (scan_cfg.care[j] &&
          window_q[int'(scan_cfg.len) - 1 - j] != scan_cfg.pattern[ByteW*j +: ByteW]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic scan_byte(input logic [ByteW-1:0] b, input logic last);
    scan_result_t res;
    for (int k = MaxPatternBytes - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = b;
    if (seen_cnt != '1) seen_cnt++;
    if (!reported) begin
      if (window_hit()) begin
        res.found        = 1'b1;
        res.match_offset = seen_cnt - CntW'(scan_cfg.len);
        reported         = 1'b1;
        verdict_q        = {verdict_q, res};
      end else if (last) begin
        res       = '0;
        verdict_q = {verdict_q, res};
      end
    end
    if (last) begin
      seen_cnt = '0;
      reported = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cfg = '0;
      foreach (window_q[k]) window_q[k] = '0;
      seen_cnt   = '0;
      reported   = 1'b0;
      verdict_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      results_o  = 0;
      hits_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAT_LOW:  scan_cfg.pattern[CfgDataW-1:0]          = cfg_wdata_i;
          CFG_PAT_HIGH: scan_cfg.pattern[2*CfgDataW-1:CfgDataW] = cfg_wdata_i;
          CFG_CARE:     scan_cfg.care = cfg_wdata_i[CareW-1:0];
          CFG_LEN:      scan_cfg.len  = cfg_wdata_i[LenW-1:0];
          default: ;
        endcase
      end

      // result beat is from an earlier byte, so pop before scanning this edge's byte
      if (out_i.valid && out_i.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result beat: found=%0d match_offset=%0d",
                 out_i.found, out_i.match_offset);
          fail_cnt_o++;
        end else begin
          want = verdict_q.pop_front();
          results_o++;
          if (want.found) hits_o++;
          if (out_i.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_i.found);
            fail_cnt_o++;
          end
          if (out_i.match_offset !== want.match_offset) begin
            $error("match_offset: expected %0d, got %0d",
                   want.match_offset, out_i.match_offset);
            fail_cnt_o++;
          end
        end
      end

      if (in_i.valid && in_i.ready) scan_byte(in_i.data_byte, in_i.last_byte);
      pending_o = verdict_q.size();
    end
  end

endmodule

[bench/tb.sv]
module tb;
  import mbps_pkg::*;

  localparam int unsigned ItemTarget  = 1400;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 4;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  mbps_in_if  in_if ();
  mbps_out_if out_if ();

  int unsigned fail_cnt, pending, results, hit_cnt;
  int unsigned bytes_sent, buffers_sent, settings_used, stall_cycles;
  int          burst_left;
  bit          hold_req;

  logic [PatBytes*ByteW-1:0] pat;
  logic [CareW-1:0]          care;
  logic [LenW-1:0]           len;

  masked_byte_pattern_scanner DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  mbps_scoreboard u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_i       (out_if),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .results_o   (results),
    .hits_o      (hit_cnt)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles == IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       tick;
    out_if.ready = 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_req) begin
          out_if.ready <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
          hold_req = 1'b0;
        end
        tick++;
        case (mode)
          RX_ALWAYS:  out_if.ready <= 1'b1;
          RX_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  out_if.ready <= ($urandom_range(0, 3) == 0);
          default:    out_if.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  // upper bits of the narrow registers carry junk; the block must mask them
  task automatic load_pattern(input logic [PatBytes*ByteW-1:0] p, input logic [CareW-1:0] c,
                              input logic [LenW-1:0] l);
    pat  = p;
    care = c;
    len  = l;
    write_reg(CFG_PAT_LOW, p[CfgDataW-1:0]);
    write_reg(CFG_PAT_HIGH, p[2*CfgDataW-1:CfgDataW]);
    write_reg(CFG_CARE, {$urandom, 16'($urandom), c});
    write_reg(CFG_LEN, {$urandom, 27'($urandom), l});
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CfgIdxW'(CFG_LEN + CfgIdxW'($urandom_range(1, 4))), {$urandom, $urandom});
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic put_beat(input logic [ByteW-1:0] b, input logic last);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_chunk(input logic [ByteW-1:0] chunk [$]);
    foreach (chunk[i]) put_beat(chunk[i], i == chunk.size() - 1);
    buffers_sent++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // noise mixes random bytes and pattern bytes for near misses; most buffers get a planted copy
  task automatic random_chunk(output logic [ByteW-1:0] chunk [$]);
    int n;
    int pos;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
    chunk = {};
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) chunk = {chunk, ByteW'($urandom)};
      else chunk = {chunk, pat[ByteW*$urandom_range(0, PatBytes-1) +: ByteW]};
    end
    if (len >= 1 && len <= MaxPatternBytes && n >= int'(len) && $urandom_range(0, 4) != 0) begin
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(0, n - int'(len));
        for (int j = 0; j < int'(len); j++) begin
          if (care[j]) chunk[pos+j] = pat[ByteW*j +: ByteW];
        end
      end
    end
  endtask

  task automatic random_setting(input int phase);
    logic [PatBytes*ByteW-1:0] p;
    logic [CareW-1:0]          c;
    logic [LenW-1:0]           l;
    int                        r;
    p = {$urandom, $urandom, $urandom, $urandom};
    case (phase)
      0: load_pattern(p, '1, LenW'(MaxPatternBytes));
      1: load_pattern('1, '1, LenW'(MaxPatternBytes));
      2: load_pattern(p, '0, '1);
      3: load_pattern(p, '1, LenW'($urandom_range(1, 8)));
      default: begin
        if ($urandom_range(0, 7) == 0) p = '0;
        r = $urandom_range(0, 9);
        if (r == 0)      l = '0;
        else if (r == 1) l = LenW'(MaxPatternBytes);
        else if (r == 2) l = LenW'($urandom_range(MaxPatternBytes + 1, 31));
        else             l = LenW'($urandom_range(1, 8));
        r = $urandom_range(0, 5);
        if (r < 3)       c = '1;
        else if (r == 3) c = '0;
        else             c = CareW'($urandom);
        load_pattern(p, c, l);
      end
    endcase
  endtask

  initial begin
    logic [ByteW-1:0] chunk [$];
    int               nbuf;
    int               phase;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_PAT_LOW;
    cfg_wdata_i     = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    hold_req        = 1'b0;
    burst_left      = 0;
    stall_cycles    = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: zero length never matches
    send_chunk('{8'hFF});
    settle();

    // two-byte pattern: hit on the last byte at offset 0, short buffer, second hit suppressed
    load_pattern(128'h00FF, 16'h0003, 5'd2);
    send_chunk('{8'hFF, 8'h00});
    send_chunk('{8'hFF});
    send_chunk('{8'h12, 8'hFF, 8'h00, 8'hFF, 8'h00});
    settle();

    // wildcard in the middle
    load_pattern(128'h5577AA, 16'h0005, 5'd3);
    send_chunk('{8'hAA, 8'h3C, 8'h55});
    settle();

    // all wildcards: stale window bytes must not count toward a short buffer
    load_pattern(128'h5577AA, 16'h0000, 5'd3);
    send_chunk('{8'h01, 8'h02});
    send_chunk('{8'h03, 8'h04, 8'h05});
    settle();

    // length above the window never matches
    load_pattern('0, '0, LenW'(MaxPatternBytes + 1));
    send_chunk('{8'h00});
    settle();

    phase = 0;
    while (bytes_sent < ItemTarget) begin
      random_setting(phase);
      nbuf = $urandom_range(6, 14);
      for (int i = 0; i < nbuf; i++) begin
        if (phase == 3 && i == nbuf / 2) hold_req = 1'b1;
        random_chunk(chunk);
        send_chunk(chunk);
      end
      settle();
      phase++;
    end

    repeat (8) @(negedge clk_i);
    $display("scanned %0d bytes in %0d buffers under %0d register settings",
             bytes_sent, buffers_sent, settings_used);
    $display("%0d results checked, %0d matches, one %0d-cycle receiver hold-off",
             results, hit_cnt, HoldCycles);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_if.sv
hw/rtl/mbps_matcher.sv
hw/rtl/masked_byte_pattern_scanner.sv
hw/rtl/mbps_checker.sv
bench/mbps_checker.sv
bench/tb.sv
